FILE: rtl/core/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants for the suffix automaton builder.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int MAX_TEXT_LEN  = 512;
    localparam int ALPHABET_SIZE = 256;
    localparam int MAX_STATES    = 2 * MAX_TEXT_LEN - 1;
    localparam int ST_W          = 10;
    localparam int SYM_W         = 8;
    localparam int LINK_W        = ST_W + 1;
    localparam int ST_DEPTH      = 1 << ST_W;
    localparam int TT_AW         = ST_W + SYM_W;
    localparam int TT_DEPTH      = 1 << TT_AW;

    // link word: top bit marks "no link"
    localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {ST_W{1'b0}}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_L_RD,
        S_L_EV,
        S_Q_RD,
        S_Q_EV,
        S_CHECK,
        S_W_RD,
        S_W_EV,
        S_CP,
        S_R_RD,
        S_R_EV,
        S_LINK_Q,
        S_SET_LINK,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic [ST_W-1:0] new_state;
        logic [ST_W-1:0] new_link;
        logic            cloned;
        logic [ST_W-1:0] clone_state;
        logic [ST_W-1:0] state_count;
        logic            full_res;
    } t_res;

endpackage

FILE: rtl/core/sab_ram.sv
// ----------------------------------------------------------------------------
// sab_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sab_seq.sv
// ----------------------------------------------------------------------------
// sab_seq
// Sequencer that walks suffix links over the state stores, one memory access
// step at a time, and builds the result of each symbol.
// ----------------------------------------------------------------------------
module sab_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sab_pkg::SYM_W-1:0] i_sym,
    input  logic                      i_busy,
    output logic                      o_idle,
    output logic                      o_res_valid,
    output sab_pkg::t_res             o_res
);
    import sab_pkg::*;

    t_seq_state r_state, n_state;

    logic [TT_AW-1:0]  r_clr, n_clr;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [ST_W-1:0]   r_p, n_p;
    logic [ST_W-1:0]   r_q, n_q;
    logic [ST_W-1:0]   r_lenp, n_lenp;
    logic [ST_W-1:0]   r_lenlast, n_lenlast;
    logic [LINK_W-1:0] r_linkq, n_linkq;
    logic              r_need2, n_need2;
    logic              r_first, n_first;
    logic [ST_W-1:0]   r_cur, n_cur;
    logic [ST_W-1:0]   r_cln, n_cln;
    logic [ST_W-1:0]   r_used, n_used;
    logic [ST_W-1:0]   r_last, n_last;
    logic [ST_W-1:0]   r_linkcur, n_linkcur;
    logic [SYM_W:0]    r_idx, n_idx;
    logic [SYM_W-1:0]  r_widx, n_widx;
    logic              r_cpv, n_cpv;
    t_res              r_res, n_res;

    logic              tt_we, len_we, link_we;
    logic [TT_AW-1:0]  tt_waddr, tt_raddr;
    logic [ST_W-1:0]   tt_wdata, tt_rdata;
    logic [ST_W-1:0]   len_waddr, len_raddr, len_wdata, len_rdata;
    logic [ST_W-1:0]   link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_rdata;

    sab_ram #(.W(ST_W), .D(TT_DEPTH)) u_tt (
        .i_clk(i_clk), .i_we(tt_we), .i_waddr(tt_waddr), .i_wdata(tt_wdata),
        .i_raddr(tt_raddr), .o_rdata(tt_rdata)
    );
    sab_ram #(.W(ST_W), .D(ST_DEPTH)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr), .i_wdata(len_wdata),
        .i_raddr(len_raddr), .o_rdata(len_rdata)
    );
    sab_ram #(.W(LINK_W), .D(ST_DEPTH)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr),
        .i_wdata(link_wdata), .i_raddr(link_raddr), .o_rdata(link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= ST_W'(1);
            r_last  <= '0;
            r_cpv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
            r_last  <= n_last;
            r_cpv   <= n_cpv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym     <= n_sym;
        r_p       <= n_p;
        r_q       <= n_q;
        r_lenp    <= n_lenp;
        r_lenlast <= n_lenlast;
        r_linkq   <= n_linkq;
        r_need2   <= n_need2;
        r_first   <= n_first;
        r_cur     <= n_cur;
        r_cln     <= n_cln;
        r_linkcur <= n_linkcur;
        r_idx     <= n_idx;
        r_widx    <= n_widx;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_sym     = r_sym;
        n_p       = r_p;
        n_q       = r_q;
        n_lenp    = r_lenp;
        n_lenlast = r_lenlast;
        n_linkq   = r_linkq;
        n_need2   = r_need2;
        n_first   = r_first;
        n_cur     = r_cur;
        n_cln     = r_cln;
        n_used    = r_used;
        n_last    = r_last;
        n_linkcur = r_linkcur;
        n_idx     = r_idx;
        n_widx    = r_widx;
        n_cpv     = r_cpv;
        n_res     = r_res;

        tt_we      = 1'b0;
        tt_waddr   = {r_p, r_sym};
        tt_wdata   = r_cur;
        tt_raddr   = {r_p, r_sym};
        len_we     = 1'b0;
        len_waddr  = r_cur;
        len_wdata  = r_lenlast + ST_W'(1);
        len_raddr  = r_p;
        link_we    = 1'b0;
        link_waddr = r_cur;
        link_wdata = {1'b0, r_linkcur};
        link_raddr = r_p;

        case (r_state)
            S_CLEAR: begin
                tt_we    = 1'b1;
                tt_waddr = r_clr;
                tt_wdata = '0;
                if (r_clr[TT_AW-1:ST_W] == '0) begin
                    len_we     = 1'b1;
                    len_waddr  = r_clr[ST_W-1:0];
                    len_wdata  = '0;
                    link_we    = 1'b1;
                    link_waddr = r_clr[ST_W-1:0];
                    link_wdata = (r_clr == '0) ? LINK_NONE : '0;
                end
                n_clr = r_clr + TT_AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_sym   = i_sym;
                    n_p     = r_last;
                    n_first = 1'b1;
                    n_state = S_L_RD;
                end
            end
            // look-ahead walk: find where the walk stops and if a clone is due
            S_L_RD: n_state = S_L_EV;
            S_L_EV: begin
                if (r_first) begin
                    n_lenlast = len_rdata;
                end
                n_first = 1'b0;
                if (tt_rdata != '0) begin
                    n_q     = tt_rdata;
                    n_lenp  = len_rdata;
                    n_state = S_Q_RD;
                end else if (link_rdata[ST_W]) begin
                    n_need2 = 1'b0;
                    n_state = S_CHECK;
                end else begin
                    n_p     = link_rdata[ST_W-1:0];
                    n_state = S_L_RD;
                end
            end
            S_Q_RD: begin
                len_raddr  = r_q;
                link_raddr = r_q;
                n_state    = S_Q_EV;
            end
            S_Q_EV: begin
                n_linkq = link_rdata;
                n_need2 = ({1'b0, r_lenp} + (ST_W+1)'(1)) != {1'b0, len_rdata};
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res = '0;
                if ((ST_W+1)'(r_used) + (ST_W+1)'(r_need2) + (ST_W+1)'(1)
                        > (ST_W+1)'(MAX_STATES)) begin
                    n_res.state_count = r_used;
                    n_res.full_res    = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    n_cur     = r_used;
                    n_cln     = '0;
                    n_used    = r_used + ST_W'(1);
                    len_we    = 1'b1;
                    len_waddr = r_used;
                    len_wdata = r_lenlast + ST_W'(1);
                    n_p       = r_last;
                    n_state   = S_W_RD;
                end
            end
            // second walk: add transitions to the new state
            S_W_RD: n_state = S_W_EV;
            S_W_EV: begin
                if (tt_rdata == '0) begin
                    tt_we    = 1'b1;
                    tt_waddr = {r_p, r_sym};
                    tt_wdata = r_cur;
                    if (link_rdata[ST_W]) begin
                        n_linkcur = '0;
                        n_state   = S_SET_LINK;
                    end else begin
                        n_p     = link_rdata[ST_W-1:0];
                        n_state = S_W_RD;
                    end
                end else if (!r_need2) begin
                    n_linkcur = r_q;
                    n_state   = S_SET_LINK;
                end else begin
                    n_cln      = r_used;
                    n_used     = r_used + ST_W'(1);
                    len_we     = 1'b1;
                    len_waddr  = r_used;
                    len_wdata  = r_lenp + ST_W'(1);
                    link_we    = 1'b1;
                    link_waddr = r_used;
                    link_wdata = r_linkq;
                    n_idx      = '0;
                    n_cpv      = 1'b0;
                    n_state    = S_CP;
                end
            end
            // row copy q -> clone, read and write overlapped one entry apart
            S_CP: begin
                tt_raddr = {r_q, r_idx[SYM_W-1:0]};
                if (r_cpv) begin
                    tt_we    = 1'b1;
                    tt_waddr = {r_cln, r_widx};
                    tt_wdata = tt_rdata;
                end
                n_cpv  = !r_idx[SYM_W];
                n_widx = r_idx[SYM_W-1:0];
                n_idx  = r_idx + (SYM_W+1)'(1);
                if (r_idx[SYM_W] && !r_cpv) begin
                    n_state = S_R_RD;
                end
            end
            // redirect transitions on the symbol from q to the clone
            S_R_RD: n_state = S_R_EV;
            S_R_EV: begin
                if (tt_rdata == r_q) begin
                    tt_we    = 1'b1;
                    tt_waddr = {r_p, r_sym};
                    tt_wdata = r_cln;
                    if (link_rdata[ST_W]) begin
                        n_state = S_LINK_Q;
                    end else begin
                        n_p     = link_rdata[ST_W-1:0];
                        n_state = S_R_RD;
                    end
                end else begin
                    n_state = S_LINK_Q;
                end
            end
            S_LINK_Q: begin
                link_we    = 1'b1;
                link_waddr = r_q;
                link_wdata = {1'b0, r_cln};
                n_linkcur  = r_cln;
                n_state    = S_SET_LINK;
            end
            S_SET_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
                link_wdata = {1'b0, r_linkcur};
                n_last     = r_cur;
                n_res.new_state   = r_cur;
                n_res.new_link    = r_linkcur;
                n_res.cloned      = r_cln != '0;
                n_res.clone_state = r_cln;
                n_res.state_count = r_used;
                n_res.full_res    = 1'b0;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!i_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle      = r_state == S_IDLE;
    assign o_res_valid = (r_state == S_DONE) && !i_busy;
    assign o_res       = r_res;

endmodule

FILE: rtl/core/suffix_automaton_builder.sv
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton construction, one text byte per transaction.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 262144 entries of its transition memory to
// zero, one entry per cycle, and takes no symbol meanwhile. Each symbol is then
// handled by a sequencer over three single-port-read memories: every
// suffix-link step is an address state followed by a state that takes the
// registered data, and the link chain is walked twice, once to look ahead and
// once to add transitions. A clone adds the copy of a 256-entry row, a
// redirect walk made of the same steps and a state that relinks the cloned
// state. The result sits in an output register, so the next symbol is taken
// while it waits.
module suffix_automaton_builder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [sab_pkg::SYM_W-1:0] i_symbol,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [sab_pkg::ST_W-1:0] o_new_state,
    output logic [sab_pkg::ST_W-1:0] o_new_link,
    output logic                     o_cloned,
    output logic [sab_pkg::ST_W-1:0] o_clone_state,
    output logic [sab_pkg::ST_W-1:0] o_state_count,
    output logic                     o_full_res
);
    import sab_pkg::*;

    logic  seq_idle, res_valid, busy;
    t_res  res;
    logic  r_ovalid;
    t_res  r_out;

    assign busy = r_ovalid && i_out_stall;

    sab_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_in_valid), .i_sym(i_symbol), .i_busy(busy),
        .o_idle(seq_idle), .o_res_valid(res_valid), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_in_stall    = !seq_idle;
    assign o_out_valid   = r_ovalid;
    assign o_new_state   = r_out.new_state;
    assign o_new_link    = r_out.new_link;
    assign o_cloned      = r_out.cloned;
    assign o_clone_state = r_out.clone_state;
    assign o_state_count = r_out.state_count;
    assign o_full_res    = r_out.full_res;

`ifndef NO_ASSERTIONS
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_res) |-> (o_new_state == '0 && !o_cloned))
        else $error("dropped symbol reports a state");
    a_clone_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cloned) |-> (o_clone_state == o_new_state + ST_W'(1)))
        else $error("clone index is not right after the new state");
    a_new_nonroot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_full_res) |-> (o_new_state != '0))
        else $error("new state is the root");
`endif

endmodule
